>>> src/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication, reset masked
`define PESQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset too
`define PESQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pesq_pkg.sv
`default_nettype none
package pesq_pkg;

  localparam int unsigned VOICES     = 4;
  localparam int unsigned DATA_DEPTH = 4096;
  localparam int unsigned CHANNELS   = 4;
  localparam int unsigned SLOTS      = CHANNELS * VOICES;
  localparam int unsigned AW         = $clog2(DATA_DEPTH);
  localparam int unsigned SW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned VW         = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW         = $clog2(VOICES + 1);

  localparam logic [14:0] AGE_MAX    = 15'h7fff;
  localparam logic [7:0]  MUTE_BASE  = 8'h9f;
  localparam logic [7:0]  VOL_BASE   = 8'h90;
  localparam logic [7:0]  DIV_BASE   = 8'h80;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_WAIT = 2'd0,
    CMD_VOL  = 2'd1,
    CMD_DIV  = 2'd2,
    CMD_BOTH = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUTE,
    ST_HDR_HI,
    ST_HDR_LO,
    ST_LIST_CNT,
    ST_ENT_HI,
    ST_ENT_LO,
    ST_CHAN,
    ST_SLOT,
    ST_CMD,
    ST_ARG,
    ST_EMIT
  } state_e;

endpackage
`default_nettype wire

>>> src/pesq_ram.sv
`default_nettype none
module pesq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> src/psg_effect_sequencer_core.sv
`default_nettype none
// Channel  Dir  tdata bits (low first)                            tuser/tlast
// s_axis   in   op[1:0] address[13:2] data_value[21:14]           -
//               effect_index[32:22], zero pad to 40
// m_axis   out  psg_byte[7:0]                                     tlast = last
//
// Load: a single store write. Start: 4 mute beats, header and list count reads, then
// three reads per stream, plus output stalls. Tick: each slot in turn, a command slot
// also reading its command and any argument (one store read port, one slot served at
// a time), then three bytes per sounding channel; silent channels are skipped.
// Reset clears slot control, volumes, dividers and playing; store is not cleared.
// Output holds in a register; a stall there only holds up the mute and byte emit steps.
`include "assert_macros.svh"
module psg_effect_sequencer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // op, address, data_value, effect_index
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [7:0]  m_axis_tdata_o,   // psg_byte
  output logic             m_axis_tlast_o
);

  localparam int unsigned AW = pesq_pkg::AW;
  localparam int unsigned SW = pesq_pkg::SW;
  localparam int unsigned VW = pesq_pkg::VW;
  localparam int unsigned CW = pesq_pkg::CW;
  localparam int unsigned SLOTS  = pesq_pkg::SLOTS;
  localparam int unsigned VOICES = pesq_pkg::VOICES;

  pesq_pkg::state_e state_q, state_d;

  logic [1:0]  in_op;
  logic [11:0] in_addr;
  logic [7:0]  in_data;
  logic [10:0] in_idx;
  logic        in_acc;

  assign in_op   = s_axis_tdata_i[1:0];
  assign in_addr = s_axis_tdata_i[13:2];
  assign in_data = s_axis_tdata_i[21:14];
  assign in_idx  = s_axis_tdata_i[32:22];
  assign s_axis_tready_o = (state_q == pesq_pkg::ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // slot state
  logic        act_q  [SLOTS];
  logic [AW-1:0] ptr_q [SLOTS];
  logic [5:0]  wait_q [SLOTS];
  logic [14:0] age_q  [SLOTS];
  logic [3:0]  vol_q  [SLOTS];
  logic [11:0] div_q  [SLOTS];
  logic        playing_q;

  // sequencer registers
  logic [AW-1:0] h_q, p_q, e_q;
  logic [7:0]    hi_q, cnt_q, m_q;
  logic [SW-1:0] s_q;
  logic [1:0]    ch_q, k_q;

  logic          out_valid_q, out_last_q;
  logic [7:0]    out_byte_q;
  logic          can_load, out_load, out_last;
  logic [7:0]    out_byte;

  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic [15:0]   h_full;

  assign h_full = 16'd2 + {4'd0, in_idx, 1'b0};

  pesq_ram #(.Width(8), .Depth(pesq_pkg::DATA_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && (in_op == pesq_pkg::OP_LOAD)),
    .waddr_i (AW'({4'd0, in_addr})),
    .wdata_i (in_data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // per-channel activity
  logic [3:0] ch_any;
  logic [CW-1:0] ch_cnt [3];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ch_any[c] = 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        ch_any[c] = ch_any[c] | act_q[c*VOICES+v];
      end
    end
    for (int c = 0; c < 3; c++) begin
      ch_cnt[c] = '0;
      for (int v = 0; v < VOICES; v++) begin
        ch_cnt[c] = ch_cnt[c] + CW'(act_q[c*VOICES+v]);
      end
    end
  end

  // stream placement: channel then slot
  logic [1:0]    pl_ch;
  logic [CW-1:0] pl_best;
  logic          pl_done;
  logic [VW-1:0] pl_v;
  logic          pl_free;
  logic [14:0]   pl_old;
  logic          pl_have;
  logic [SW-1:0] pl_slot;
  always_comb begin
    pl_ch   = rdata[1:0];
    pl_best = CW'(VOICES);
    pl_done = 1'b0;
    if (!rdata[1]) begin
      for (int i = 2; i >= 0; i--) begin
        if (!pl_done) begin
          if (ch_cnt[i] == '0) begin
            pl_ch = 2'(i);
            pl_done = 1'b1;
          end else if (ch_cnt[i] < pl_best) begin
            pl_best = ch_cnt[i];
            pl_ch = 2'(i);
          end
        end
      end
    end
    pl_v    = '0;
    pl_free = 1'b0;
    for (int v = 0; v < VOICES; v++) begin
      if (!pl_free && !act_q[32'(pl_ch)*VOICES+v]) begin
        pl_v = VW'(v);
        pl_free = 1'b1;
      end
    end
    pl_old  = '0;
    pl_have = 1'b0;
    if (!pl_free) begin
      for (int v = 0; v < VOICES; v++) begin
        if (!pl_have || age_q[32'(pl_ch)*VOICES+v] > pl_old) begin
          pl_old = age_q[32'(pl_ch)*VOICES+v];
          pl_v = VW'(v);
          pl_have = 1'b1;
        end
      end
    end
    pl_slot = SW'(32'(pl_ch) * VOICES + 32'(pl_v));
  end

  // loudest slot of the emitting channel
  logic [SW-1:0] ls_slot;
  logic [4:0]    ls_best;
  logic          later_any;
  always_comb begin
    ls_slot = SW'(32'(ch_q) * VOICES);
    ls_best = 5'd16;
    for (int v = 0; v < VOICES; v++) begin
      if (act_q[32'(ch_q)*VOICES+v] && {1'b0, vol_q[32'(ch_q)*VOICES+v]} < ls_best) begin
        ls_best = {1'b0, vol_q[32'(ch_q)*VOICES+v]};
        ls_slot = SW'(32'(ch_q) * VOICES + v);
      end
    end
    later_any = 1'b0;
    for (int c = 0; c < 4; c++) begin
      if (2'(c) > ch_q) begin
        later_any = later_any | ch_any[c];
      end
    end
  end

  logic last_slot;
  logic run_cmd;
  assign last_slot = (32'(s_q) == SLOTS - 1);
  assign run_cmd   = act_q[s_q] && (wait_q[s_q] == '0);
  assign can_load  = !out_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pesq_pkg::ST_IDLE: begin
        if (in_acc && in_op == pesq_pkg::OP_START) begin
          state_d = pesq_pkg::ST_MUTE;
        end else if (in_acc && in_op == pesq_pkg::OP_TICK && playing_q) begin
          state_d = pesq_pkg::ST_SLOT;
        end
      end
      pesq_pkg::ST_MUTE:     if (can_load && k_q == 2'd3) state_d = pesq_pkg::ST_HDR_HI;
      pesq_pkg::ST_HDR_HI:   state_d = pesq_pkg::ST_HDR_LO;
      pesq_pkg::ST_HDR_LO:   state_d = pesq_pkg::ST_LIST_CNT;
      pesq_pkg::ST_LIST_CNT: state_d = (rdata == '0) ? pesq_pkg::ST_IDLE : pesq_pkg::ST_ENT_HI;
      pesq_pkg::ST_ENT_HI:   state_d = pesq_pkg::ST_ENT_LO;
      pesq_pkg::ST_ENT_LO:   state_d = pesq_pkg::ST_CHAN;
      pesq_pkg::ST_CHAN:     state_d = (cnt_q == 8'd1) ? pesq_pkg::ST_IDLE : pesq_pkg::ST_ENT_HI;
      pesq_pkg::ST_SLOT: begin
        if (run_cmd) state_d = pesq_pkg::ST_CMD;
        else if (last_slot) state_d = pesq_pkg::ST_EMIT;
      end
      pesq_pkg::ST_CMD: begin
        if (rdata[7]) state_d = pesq_pkg::ST_ARG;
        else state_d = last_slot ? pesq_pkg::ST_EMIT : pesq_pkg::ST_SLOT;
      end
      pesq_pkg::ST_ARG: state_d = last_slot ? pesq_pkg::ST_EMIT : pesq_pkg::ST_SLOT;
      pesq_pkg::ST_EMIT: begin
        if (ch_q == 2'd3 && (!ch_any[ch_q] || (can_load && k_q == 2'd2))) begin
          state_d = pesq_pkg::ST_IDLE;
        end
      end
      default: state_d = pesq_pkg::ST_IDLE;
    endcase
  end

  // outputs: store read address and output byte
  always_comb begin
    raddr    = h_q;
    out_load = 1'b0;
    out_byte = '0;
    out_last = 1'b0;
    unique case (state_q)
      pesq_pkg::ST_IDLE:     raddr = AW'(h_full);
      pesq_pkg::ST_MUTE: begin
        raddr    = h_q;
        out_load = can_load;
        out_byte = pesq_pkg::MUTE_BASE | {1'b0, k_q, 5'd0};
        out_last = (k_q == 2'd3);
      end
      pesq_pkg::ST_HDR_HI:   raddr = h_q + AW'(1);
      pesq_pkg::ST_HDR_LO:   raddr = AW'({hi_q, rdata});
      pesq_pkg::ST_LIST_CNT: raddr = p_q;
      pesq_pkg::ST_ENT_HI:   raddr = p_q + AW'(1);
      pesq_pkg::ST_ENT_LO:   raddr = AW'({hi_q, rdata});
      pesq_pkg::ST_CHAN:     raddr = p_q;
      pesq_pkg::ST_SLOT:     raddr = ptr_q[s_q];
      pesq_pkg::ST_CMD:      raddr = ptr_q[s_q] + AW'(1);
      pesq_pkg::ST_ARG:      raddr = h_q;
      pesq_pkg::ST_EMIT: begin
        out_load = can_load && ch_any[ch_q];
        out_last = (k_q == 2'd2) && !later_any;
        unique case (k_q)
          2'd0:    out_byte = pesq_pkg::VOL_BASE | {1'b0, ch_q, 1'b0, vol_q[ls_slot]};
          2'd1:    out_byte = pesq_pkg::DIV_BASE | {1'b0, ch_q, 1'b0, div_q[ls_slot][3:0]};
          default: out_byte = div_q[ls_slot][11:4];
        endcase
      end
      default: raddr = h_q;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pesq_pkg::ST_IDLE;
      s_q  <= '0;
      ch_q <= '0;
      k_q  <= '0;
      cnt_q <= '0;
      playing_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_last_q  <= out_last;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        pesq_pkg::ST_IDLE: begin
          s_q  <= '0;
          ch_q <= '0;
          k_q  <= '0;
          if (in_acc && in_op == pesq_pkg::OP_START) playing_q <= 1'b1;
        end
        pesq_pkg::ST_MUTE:     if (can_load) k_q <= k_q + 2'd1;
        pesq_pkg::ST_LIST_CNT: cnt_q <= rdata;
        pesq_pkg::ST_CHAN:     cnt_q <= cnt_q - 8'd1;
        pesq_pkg::ST_SLOT:     if (!run_cmd) s_q <= s_q + SW'(1);
        pesq_pkg::ST_CMD:      if (!rdata[7]) s_q <= s_q + SW'(1);
        pesq_pkg::ST_ARG:      s_q <= s_q + SW'(1);
        pesq_pkg::ST_EMIT: begin
          if (!ch_any[ch_q]) begin
            ch_q <= ch_q + 2'd1;
          end else if (can_load) begin
            if (k_q == 2'd2) begin
              k_q  <= '0;
              ch_q <= ch_q + 2'd1;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (out_load) out_byte_q <= out_byte;
    unique case (state_q)
      pesq_pkg::ST_IDLE:   h_q <= AW'(h_full);
      pesq_pkg::ST_HDR_HI: hi_q <= rdata;
      pesq_pkg::ST_HDR_LO: p_q <= AW'({hi_q, rdata}) + AW'(1);
      pesq_pkg::ST_ENT_HI: hi_q <= rdata;
      pesq_pkg::ST_ENT_LO: begin
        e_q <= AW'({hi_q, rdata});
        p_q <= p_q + AW'(2);
      end
      pesq_pkg::ST_CMD:    m_q <= rdata;
      default: ;
    endcase
  end

  // slot state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        act_q[i]  <= 1'b0;
        wait_q[i] <= '0;
        age_q[i]  <= '0;
        vol_q[i]  <= '0;
        div_q[i]  <= '0;
        ptr_q[i]  <= '0;
      end
    end else begin
      unique case (state_q)
        pesq_pkg::ST_IDLE: begin
          if (in_acc && in_op == pesq_pkg::OP_START) begin
            for (int i = 0; i < SLOTS; i++) begin
              act_q[i]  <= 1'b0;
              wait_q[i] <= '0;
            end
          end
        end
        pesq_pkg::ST_CHAN: begin
          act_q[pl_slot]  <= 1'b1;
          ptr_q[pl_slot]  <= e_q + AW'(1);
          wait_q[pl_slot] <= '0;
          age_q[pl_slot]  <= '0;
        end
        pesq_pkg::ST_SLOT: begin
          if (act_q[s_q]) begin
            if (age_q[s_q] != pesq_pkg::AGE_MAX) age_q[s_q] <= age_q[s_q] + 15'd1;
            if (wait_q[s_q] != '0) wait_q[s_q] <= wait_q[s_q] - 6'd1;
          end
        end
        pesq_pkg::ST_CMD: begin
          unique case (pesq_pkg::cmd_e'(rdata[7:6]))
            pesq_pkg::CMD_WAIT: begin
              ptr_q[s_q] <= ptr_q[s_q] + AW'(1);
              if (rdata == '0) act_q[s_q] <= 1'b0;
              else wait_q[s_q] <= rdata[5:0] - 6'd1;
            end
            pesq_pkg::CMD_VOL: begin
              ptr_q[s_q] <= ptr_q[s_q] + AW'(1);
              vol_q[s_q] <= rdata[3:0];
            end
            default: ;
          endcase
        end
        pesq_pkg::ST_ARG: begin
          ptr_q[s_q] <= ptr_q[s_q] + AW'(2);
          if (m_q[6]) begin
            vol_q[s_q] <= m_q[5:2];
            div_q[s_q] <= {2'b00, m_q[1:0], rdata};
          end else begin
            div_q[s_q] <= {m_q[3:0], rdata};
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

  `PESQ_ASSERT(a_start_plays, clk_i, rst_ni, in_acc && in_op == pesq_pkg::OP_START |=> playing_q, "start did not set playing")
  `PESQ_ASSERT(a_out_held, clk_i, rst_ni, out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_byte_q), "output beat dropped")
  `PESQ_ASSERT(a_busy_no_accept, clk_i, rst_ni, in_acc && in_op == pesq_pkg::OP_START |=> !s_axis_tready_o, "start did not enter sequence")

endmodule
`default_nettype wire

>>> tb/tb_psg_effect_sequencer_core.sv
`default_nettype none
module tb_psg_effect_sequencer_core;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned N_RANDOM    = 30;

  // Mirror of the sequencer: store, slots and the queue of PSG bytes still owed.
  class psg_scoreboard;
    logic [7:0]  mem [pesq_pkg::DATA_DEPTH];
    logic        active [pesq_pkg::SLOTS];
    logic [11:0] ptr [pesq_pkg::SLOTS];
    logic [5:0]  wt [pesq_pkg::SLOTS];
    logic [14:0] age [pesq_pkg::SLOTS];
    logic [3:0]  vol [pesq_pkg::SLOTS];
    logic [11:0] div [pesq_pkg::SLOTS];
    logic        playing;
    logic [8:0]  psg_owed [$];   // {last, byte}
    int unsigned errors;
    int unsigned bytes_seen;

    function new();
      for (int i = 0; i < pesq_pkg::SLOTS; i++) begin
        active[i] = 0; ptr[i] = '0; wt[i] = '0; age[i] = '0; vol[i] = '0; div[i] = '0;
      end
      playing = 0;
      errors = 0;
      bytes_seen = 0;
    endfunction

    function logic [7:0] rd(int unsigned a);
      return mem[a % pesq_pkg::DATA_DEPTH];
    endfunction

    function void place_stream(logic [7:0] code, int unsigned off);
      int unsigned ch, best, cnt, slot;
      bit found;
      int oldest;
      ch = code & 3;
      if (ch < 2) begin
        best = pesq_pkg::VOICES;
        for (int i = 2; i >= 0; i--) begin
          cnt = 0;
          for (int j = 0; j < pesq_pkg::VOICES; j++) cnt += active[i*pesq_pkg::VOICES+j];
          if (cnt == 0) begin
            ch = i;
            break;
          end
          if (cnt < best) begin
            best = cnt;
            ch = i;
          end
        end
      end
      found = 0;
      slot = 0;
      for (int i = 0; i < pesq_pkg::VOICES; i++)
        if (!found && !active[ch*pesq_pkg::VOICES+i]) begin
          slot = i;
          found = 1;
        end
      if (!found) begin
        oldest = -1;
        for (int i = 0; i < pesq_pkg::VOICES; i++)
          if (int'(age[ch*pesq_pkg::VOICES+i]) > oldest) begin
            oldest = age[ch*pesq_pkg::VOICES+i];
            slot = i;
          end
      end
      slot += ch * pesq_pkg::VOICES;
      active[slot] = 1;
      ptr[slot] = 12'(off % pesq_pkg::DATA_DEPTH);
      wt[slot] = '0;
      age[slot] = '0;
    endfunction

    function void run_slot(int unsigned s);
      logic [11:0] p;
      logic [7:0] m;
      if (age[s] != pesq_pkg::AGE_MAX) age[s]++;
      if (wt[s] != 0) begin
        wt[s]--;
        return;
      end
      p = ptr[s];
      m = mem[p];
      p = p + 12'd1;
      case (pesq_pkg::cmd_e'(m[7:6]))
        pesq_pkg::CMD_WAIT: if (m == 0) active[s] = 0; else wt[s] = 6'(m[5:0] - 6'd1);
        pesq_pkg::CMD_VOL:  vol[s] = m[3:0];
        pesq_pkg::CMD_DIV: begin
          div[s] = {m[3:0], mem[p]};
          p = p + 12'd1;
        end
        default: begin
          vol[s] = m[5:2];
          div[s] = {2'b00, m[1:0], mem[p]};
          p = p + 12'd1;
        end
      endcase
      ptr[s] = p;
    endfunction

    // Called for every accepted input beat.
    function void note_input(pesq_pkg::op_e op, logic [11:0] addr, logic [7:0] dv,
                             logic [10:0] eff);
      int unsigned h, p, cnt, e, sel, best, nb;
      logic [7:0] mutes [4];
      logic [8:0] last_b;
      mutes = '{8'h9f, 8'hbf, 8'hdf, 8'hff};
      case (op)
        pesq_pkg::OP_LOAD: mem[addr] = dv;
        pesq_pkg::OP_START: begin
          for (int i = 0; i < 4; i++) psg_owed.push_back({i == 3, mutes[i]});
          for (int i = 0; i < pesq_pkg::SLOTS; i++) begin
            active[i] = 0;
            wt[i] = '0;
          end
          playing = 1;
          h = 2 + 2 * eff;
          p = (rd(h) << 8) + rd(h + 1);
          cnt = rd(p);
          p++;
          for (int i = 0; i < cnt; i++) begin
            e = (rd(p) << 8) | rd(p + 1);
            p += 2;
            place_stream(rd(e), e + 1);
          end
        end
        pesq_pkg::OP_TICK: if (playing) begin
          nb = 0;
          for (int c = 0; c < pesq_pkg::CHANNELS; c++) begin
            sel = pesq_pkg::SLOTS;
            best = 16;
            for (int v = 0; v < pesq_pkg::VOICES; v++)
              if (active[c*pesq_pkg::VOICES+v]) run_slot(c*pesq_pkg::VOICES+v);
            for (int v = 0; v < pesq_pkg::VOICES; v++)
              if (active[c*pesq_pkg::VOICES+v] && vol[c*pesq_pkg::VOICES+v] < best) begin
                best = vol[c*pesq_pkg::VOICES+v];
                sel = c*pesq_pkg::VOICES+v;
              end
            if (sel < pesq_pkg::SLOTS) begin
              psg_owed.push_back({1'b0, 8'h90 | 8'(c << 5) | {4'h0, vol[sel]}});
              psg_owed.push_back({1'b0, 8'h80 | 8'(c << 5) | {4'h0, div[sel][3:0]}});
              psg_owed.push_back({1'b0, div[sel][11:4]});
              nb += 3;
            end
          end
          if (nb > 0) begin
            last_b = psg_owed.pop_back();
            last_b[8] = 1'b1;
            psg_owed.push_back(last_b);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [7:0] b, logic l);
      logic [8:0] want;
      bytes_seen++;
      if (psg_owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected output beat byte=%h last=%b", $time, b, l);
        return;
      end
      want = psg_owed.pop_front();
      if (b !== want[7:0]) begin
        errors++;
        $display("%0t: psg_byte expected %h actual %h", $time, want[7:0], b);
      end
      if (l !== want[8]) begin
        errors++;
        $display("%0t: last expected %b actual %b", $time, want[8], l);
      end
    endfunction

    function int unsigned pending();
      return psg_owed.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;

  psg_effect_sequencer_core u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

  psg_scoreboard sb = new();
  logic [7:0] img [pesq_pkg::DATA_DEPTH];
  bit         img_used [pesq_pkg::DATA_DEPTH];
  int unsigned cyc = 0;
  int unsigned beats_in = 0;
  int unsigned starts = 0;
  int unsigned ticks = 0;
  bit hold_go = 0;
  bit fast_gaps = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    s_axis_tvalid_i = 0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes owed", cyc, sb.pending());
      $display("tb_psg_effect_sequencer_core NOT OK");
      $finish;
    end
  end

  // Output side: random ready, short and long stalls, plus a forced long hold-off.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_byte(m_axis_tdata_o, m_axis_tlast_o);
      if (hold_go) begin
        hold_go = 0;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 0;
      end else if ($urandom_range(99) < 75) begin
        m_axis_tready_i <= 1;
      end else begin
        m_axis_tready_i <= 0;
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3);
      end
    end
  end

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (fast_gaps) return (r < 90) ? 0 : 1;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_beat(pesq_pkg::op_e op, logic [11:0] addr, logic [7:0] dv,
                           logic [10:0] eff, int unsigned gap);
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i  <= {7'b0, eff, dv, addr, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(op, addr, dv, eff);
    beats_in++;
    if (op == pesq_pkg::OP_START) starts++;
    if (op == pesq_pkg::OP_TICK) ticks++;
    if (gap > 0) begin
      s_axis_tvalid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_op(pesq_pkg::op_e op, logic [10:0] eff);
    send_beat(op, 12'($urandom_range(12'h8ff, 12'h800)), 8'($urandom), eff, pick_gap());
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic void put(int unsigned a, logic [7:0] v);
    img[a % pesq_pkg::DATA_DEPTH] = v;
    img_used[a % pesq_pkg::DATA_DEPTH] = 1'b1;
  endfunction

  function automatic void put_header(int unsigned eff, int unsigned lst);
    put(2 + 2*eff, 8'(lst >> 8));
    put(3 + 2*eff, 8'(lst));
  endfunction

  // stream list: entries alternate between two stream offsets
  function automatic void put_list(int unsigned a, int unsigned n, int unsigned s0,
                                   int unsigned s1);
    int unsigned s;
    put(a, 8'(n));
    for (int j = 0; j < n; j++) begin
      s = (j % 2 == 0) ? s0 : s1;
      put(a + 1 + 2*j, 8'(s >> 8));
      put(a + 2 + 2*j, 8'(s));
    end
  endfunction

  // Effects 0..4 plus the empty effect whose header sits at the top of the store.
  function automatic void build_image();
    put_header(0, 12'h020);
    put_header(1, 12'h024);
    put_header(2, 12'h030);
    put_header(3, 12'h040);
    put_header(4, 12'h060);
    put_list(12'h020, 1, 12'h080, 12'h080);
    put_list(12'h024, 2, 12'h090, 12'h0a0);
    put_list(12'h030, 5, 12'h0b0, 12'h0b0);    // noise channel overfilled
    put_list(12'h040, 13, 12'h0c0, 12'h0c8);   // tone channels overfilled
    put_list(12'h060, 1, 12'hffe, 12'hffe);    // stream wraps past the top
    put(12'h241, 8'h00);                       // list of the top header: empty
    // tone-any: volume, divider, wait, both, zero wait, end
    put(12'h080, 8'h00); put(12'h081, 8'h4a); put(12'h082, 8'h83); put(12'h083, 8'h21);
    put(12'h084, 8'h02); put(12'h085, 8'hc7); put(12'h086, 8'h55); put(12'h087, 8'h01);
    put(12'h088, 8'h00);
    put(12'h090, 8'h01); put(12'h091, 8'h45); put(12'h092, 8'h03); put(12'h093, 8'h9f);
    put(12'h094, 8'hff); put(12'h095, 8'h4f); put(12'h096, 8'h00);
    put(12'h0a0, 8'h02); put(12'h0a1, 8'hc0); put(12'h0a2, 8'h00); put(12'h0a3, 8'h48);
    put(12'h0a4, 8'h05); put(12'h0a5, 8'h00);
    put(12'h0b0, 8'h03); put(12'h0b1, 8'h41); put(12'h0b2, 8'h02); put(12'h0b3, 8'h42);
    put(12'h0b4, 8'h03); put(12'h0b5, 8'h00);
    // long-lived tone-any streams
    put(12'h0c0, 8'h00); put(12'h0c1, 8'h43); put(12'h0c2, 8'h3f); put(12'h0c3, 8'h00);
    put(12'h0c8, 8'h01); put(12'h0c9, 8'h46); put(12'h0ca, 8'h10); put(12'h0cb, 8'h00);
    put(12'hffe, 8'h02); put(12'hfff, 8'h41); put(12'h000, 8'h00);
  endfunction

  initial begin
    int unsigned r;
    @(posedge rst_ni);
    @(posedge clk_i);
    build_image();
    // Directed: extremes of load fields, tick and unused op before any start.
    send_beat(pesq_pkg::OP_LOAD, 12'h000, 8'hff, 11'h7ff, 1);
    send_beat(pesq_pkg::OP_LOAD, 12'hfff, 8'h00, 11'h000, 0);
    send_beat(pesq_pkg::OP_TICK, 12'hfff, 8'hff, 11'h7ff, 2);
    send_beat(pesq_pkg::OP_NONE, 12'hfff, 8'hff, 11'h7ff, 1);
    fast_gaps = 1;
    for (int i = 0; i < pesq_pkg::DATA_DEPTH; i++)
      if (img_used[i]) send_beat(pesq_pkg::OP_LOAD, 12'(i), img[i], 11'($urandom), pick_gap());
    fast_gaps = 0;
    send_beat(pesq_pkg::OP_START, 12'h000, 8'h00, 11'd2046, 1);   // highest header
    send_beat(pesq_pkg::OP_TICK, 12'h000, 8'h00, 11'h000, 1);
    send_beat(pesq_pkg::OP_START, 12'hfff, 8'hff, 11'd0, 0);
    for (int i = 0; i < 5; i++) send_op(pesq_pkg::OP_TICK, 11'($urandom));
    send_op(pesq_pkg::OP_START, 11'd1);
    for (int i = 0; i < 4; i++) send_op(pesq_pkg::OP_TICK, 11'h0);
    send_op(pesq_pkg::OP_START, 11'd2);                  // eviction on the noise channel
    for (int i = 0; i < 4; i++) send_op(pesq_pkg::OP_TICK, 11'h0);
    send_op(pesq_pkg::OP_START, 11'd4);                  // wrapping stream
    for (int i = 0; i < 3; i++) send_op(pesq_pkg::OP_TICK, 11'h0);
    send_op(pesq_pkg::OP_START, 11'd3);                  // least-busy and all-full choice
    // Back pressure: receiver holds off while ticks keep coming.
    hold_go = 1;
    for (int i = 0; i < 6; i++) send_beat(pesq_pkg::OP_TICK, 12'h0, 8'h0, 11'h0, 0);
    drain();
    // Random part, mostly starts of loaded effects and ticks.
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(99);
      if (i == N_RANDOM / 2) drain();
      if (r < 60) send_op(pesq_pkg::OP_TICK, 11'($urandom));
      else if (r < 75) send_op(pesq_pkg::OP_START, ($urandom_range(7) == 0) ? 11'd2046
                                                                          : 11'($urandom_range(4)));
      else if (r < 92) send_beat(pesq_pkg::OP_LOAD, 12'($urandom_range(12'h8ff, 12'h800)),
                                 8'($urandom), 11'($urandom), pick_gap());
      else send_op(pesq_pkg::OP_NONE, 11'($urandom));
    end
    drain();
    $display("%0d input beats (%0d starts, %0d ticks), %0d output bytes checked",
             beats_in, starts, ticks, sb.bytes_seen);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_psg_effect_sequencer_core OK");
    else
      $display("tb_psg_effect_sequencer_core NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+src
src/pesq_pkg.sv
src/pesq_ram.sv
src/psg_effect_sequencer_core.sv
tb/tb_psg_effect_sequencer_core.sv
